FILE: hw/rtl/ipv4_longest_prefix_lookup_macros.svh
// assertion macros for the ipv4 longest prefix lookup block
`ifndef IPV4_LONGEST_PREFIX_LOOKUP_MACROS_SVH
`define IPV4_LONGEST_PREFIX_LOOKUP_MACROS_SVH

// checked outside reset only
`define LPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define LPM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/ipv4_lpm_pkg.sv
// types and constants shared by the ipv4 longest prefix lookup block
`timescale 1ns / 1ps
`default_nettype none

package ipv4_lpm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W     = 8;
  localparam int CNT_W       = 9;
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 4;
  localparam int CMP_W       = (IDX_W > ENTRY_W) ? ((IDX_W > CNT_W) ? IDX_W : CNT_W)
                                                 : ((ENTRY_W > CNT_W) ? ENTRY_W : CNT_W);

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic               action;
    logic [ENTRY_W-1:0] entry_index;
    logic [ADDR_W-1:0]  prefix;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  next_hop_in;
    logic [PORT_W-1:0]  port_in;
    logic [ADDR_W-1:0]  dest_addr;
  } lpm_in_t;

  typedef struct packed {
    logic               hit;
    logic [ADDR_W-1:0]  next_hop_out;
    logic [PORT_W-1:0]  port_out;
    logic [ENTRY_W-1:0] match_index;
  } lpm_out_t;

  // word moving along the chain; mask, hop and port hold the entry
  // data of a write and the best match so far of a lookup
  typedef struct packed {
    logic               action;
    logic [ENTRY_W-1:0] entry_index;
    logic [ADDR_W-1:0]  prefix;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  hop;
    logic [PORT_W-1:0]  port;
    logic [ADDR_W-1:0]  dest_addr;
    logic               found;
    logic [IDX_W-1:0]   best_idx;
  } lpm_tok_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ipv4_lpm_in_if.sv
// input channel of the ipv4 longest prefix lookup block
`timescale 1ns / 1ps
`default_nettype none

interface ipv4_lpm_in_if;
  import ipv4_lpm_pkg::*;

  logic    valid;
  logic    ready;
  lpm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipv4_lpm_out_if.sv
// result channel of the ipv4 longest prefix lookup block
`timescale 1ns / 1ps
`default_nettype none

interface ipv4_lpm_out_if;
  import ipv4_lpm_pkg::*;

  logic     valid;
  logic     ready;
  lpm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipv4_lpm_cell.sv
// one route slot of the lookup chain with its compare and forward stage
`timescale 1ns / 1ps
`default_nettype none

module ipv4_lpm_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic [ipv4_lpm_pkg::CNT_W-1:0]    limit_i,
  input  logic [ipv4_lpm_pkg::IDX_W-1:0]    cell_idx_i,
  input  logic                              vld_i,
  input  ipv4_lpm_pkg::lpm_tok_t            tok_i,
  output logic                              vld_o,
  output ipv4_lpm_pkg::lpm_tok_t            tok_o
);
  import ipv4_lpm_pkg::*;

  logic [ADDR_W-1:0] pfx_q;
  logic [ADDR_W-1:0] msk_q;
  logic [ADDR_W-1:0] nh_q;
  logic [PORT_W-1:0] port_q;

  logic     wr_hit;
  logic     in_use;
  logic     match;
  logic     better;
  logic     vld_q;
  lpm_tok_t tok_d;
  lpm_tok_t tok_q;

  always_comb begin
    wr_hit = vld_i && (tok_i.action == ACT_WRITE) &&
             (CMP_W'(tok_i.entry_index) == CMP_W'(cell_idx_i));
    in_use = CMP_W'(cell_idx_i) < CMP_W'(limit_i);
    match  = (tok_i.dest_addr & msk_q) == pfx_q;
    better = !tok_i.found || (msk_q > tok_i.mask);
    tok_d  = tok_i;
    if (vld_i && (tok_i.action == ACT_LOOKUP) && in_use && match && better) begin
      tok_d.found    = 1'b1;
      tok_d.mask     = msk_q;
      tok_d.hop      = nh_q;
      tok_d.port     = port_q;
      tok_d.best_idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && wr_hit) begin
      pfx_q  <= tok_i.prefix;
      msk_q  <= tok_i.mask;
      nh_q   <= tok_i.hop;
      port_q <= tok_i.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4_longest_prefix_lookup.sv
// ipv4 longest prefix lookup: top level with the chain of route cells
//
// usage: words enter on in_i (valid/ready). action write stores prefix, mask,
// next hop and port in slot entry_index and gives no result. action lookup
// gives one word on out_o: hit, next hop, port and slot of the matching entry
// with the greatest mask, lowest slot on a tie, all zero on a miss. only
// slots below entries_in_use (cfg_we_i / cfg_wdata_i) take part.
// every word walks the chain of TABLE_DEPTH cells, one cell per cycle while
// the chain is not held, and a lookup result then passes through the result
// register before it appears on out_o.
// one word is taken per cycle while the chain is not held, writes and lookups
// alike, in any mix; the rate is set by the chain stepping one cell a cycle.
// reset clears the valid bits of the chain and of the result register and the
// entry count; slot contents are kept; the user must write a slot before it is read.
// while a result waits and out_o.ready is low the whole chain holds and
// in_i.ready is low; it moves again in the cycle the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_longest_prefix_lookup_macros.svh"

module ipv4_longest_prefix_lookup (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipv4_lpm_pkg::CNT_W-1:0] cfg_wdata_i,
  ipv4_lpm_in_if.sink                    in_i,
  ipv4_lpm_out_if.source                 out_o
);
  import ipv4_lpm_pkg::*;

  logic [CNT_W-1:0] limit_q;
  logic             adv;
  lpm_tok_t         head_tok;
  logic             vld_c [TABLE_DEPTH+1];
  lpm_tok_t         tok_c [TABLE_DEPTH+1];
  logic             out_vld_q;
  lpm_out_t         out_d;
  lpm_out_t         out_q;
  logic             tail_wr;
  logic             res_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // a lookup starts as a miss with zero result fields
  always_comb begin
    head_tok.action      = in_i.data.action;
    head_tok.entry_index = in_i.data.entry_index;
    head_tok.prefix      = in_i.data.prefix;
    head_tok.dest_addr   = in_i.data.dest_addr;
    head_tok.found       = 1'b0;
    head_tok.best_idx    = '0;
    if (in_i.data.action == ACT_WRITE) begin
      head_tok.mask = in_i.data.mask;
      head_tok.hop  = in_i.data.next_hop_in;
      head_tok.port = in_i.data.port_in;
    end else begin
      head_tok.mask = '0;
      head_tok.hop  = '0;
      head_tok.port = '0;
    end
  end

  assign vld_c[0] = in_i.valid;
  assign tok_c[0] = head_tok;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ipv4_lpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .limit_i    (limit_q),
      .cell_idx_i (IDX_W'(g)),
      .vld_i      (vld_c[g]),
      .tok_i      (tok_c[g]),
      .vld_o      (vld_c[g+1]),
      .tok_o      (tok_c[g+1])
    );
  end

  always_comb begin
    out_d.hit          = tok_c[TABLE_DEPTH].found;
    out_d.next_hop_out = tok_c[TABLE_DEPTH].hop;
    out_d.port_out     = tok_c[TABLE_DEPTH].port;
    out_d.match_index  = ENTRY_W'(tok_c[TABLE_DEPTH].best_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_c[TABLE_DEPTH] && (tok_c[TABLE_DEPTH].action == ACT_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  assign tail_wr  = vld_c[TABLE_DEPTH] && (tok_c[TABLE_DEPTH].action == ACT_WRITE);
  assign res_zero = (out_q.next_hop_out == '0) && (out_q.port_out == '0) &&
                    (out_q.match_index == '0);

  `LPM_ASSERT(a_write_no_result, tail_wr && adv |=> !out_o.valid, "write gave a result")
  `LPM_ASSERT(a_miss_zero, out_o.valid && !out_o.data.hit |-> res_zero, "miss with nonzero fields")
  `LPM_ASSERT(a_stall_cause, !in_i.ready |-> out_o.valid && !out_o.ready, "stall without result")
  `LPM_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_vld_q && !vld_c[TABLE_DEPTH], "valid in reset")

endmodule

`default_nettype wire

FILE: dv/ipv4_lpm_route_checker.sv
// route table checker: predicts each lookup word and compares the results
`timescale 1ns / 1ps

module ipv4_lpm_route_checker
  import ipv4_lpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  ipv4_lpm_in_if           in_mon,
  ipv4_lpm_out_if          out_mon,
  output int               mismatch_cnt_o,
  output int               pending_o
);

  logic [ADDR_W-1:0] tbl_prefix   [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_mask     [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_hop      [TABLE_DEPTH];
  logic [PORT_W-1:0] tbl_port     [TABLE_DEPTH];
  logic [CNT_W-1:0]  active_routes;
  lpm_out_t          route_results_q [$];
  lpm_out_t          expected_res;
  lpm_in_t           in_word;
  int                mismatch_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;

  function automatic lpm_out_t predict_lookup(logic [ADDR_W-1:0] dest);
    lpm_out_t          res;
    logic [ADDR_W-1:0] best_mask;
    logic [IDX_W-1:0]  ix;
    int                limit;
    res = '0;
    best_mask = '0;
    limit = (active_routes > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_routes);
    for (int i = 0; i < limit; i++) begin
      ix = IDX_W'(i);
      if ((dest & tbl_mask[ix]) == tbl_prefix[ix] &&
          (!res.hit || tbl_mask[ix] > best_mask)) begin
        res.hit          = 1'b1;
        res.next_hop_out = tbl_hop[ix];
        res.port_out     = tbl_port[ix];
        res.match_index  = ENTRY_W'(i);
        best_mask        = tbl_mask[ix];
      end
    end
    return res;
  endfunction

  task automatic compare_field(string name, logic [ADDR_W-1:0] exp_v,
                               logic [ADDR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_results_q.delete();
      active_routes = '0;
      pending_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (route_results_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %h", $time, out_mon.data);
          mismatch_cnt++;
        end else begin
          expected_res = route_results_q.pop_front();
          compare_field("hit", ADDR_W'(expected_res.hit), ADDR_W'(out_mon.data.hit));
          compare_field("next_hop_out", expected_res.next_hop_out,
                        out_mon.data.next_hop_out);
          compare_field("port_out", ADDR_W'(expected_res.port_out),
                        ADDR_W'(out_mon.data.port_out));
          compare_field("match_index", ADDR_W'(expected_res.match_index),
                        ADDR_W'(out_mon.data.match_index));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        in_word = in_mon.data;
        if (in_word.action == ACT_LOOKUP) begin
          route_results_q.push_back(predict_lookup(in_word.dest_addr));
        end else begin
          tbl_prefix[in_word.entry_index] = in_word.prefix;
          tbl_mask[in_word.entry_index]   = in_word.mask;
          tbl_hop[in_word.entry_index]    = in_word.next_hop_in;
          tbl_port[in_word.entry_index]   = in_word.port_in;
        end
      end
      if (cfg_we_i) begin
        active_routes = cfg_wdata_i;
      end
      pending_o = route_results_q.size();
    end
  end

endmodule

FILE: dv/ipv4_longest_prefix_lookup_tb.sv
// testbench top for the ipv4 longest prefix lookup: stimulus, idling and verdict
`timescale 1ns / 1ps

module ipv4_longest_prefix_lookup_tb;
  import ipv4_lpm_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int DRAIN_CYCLES    = TABLE_DEPTH + 64;
  localparam int HOLD_OFF_CYCLES = 700;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  int               mismatch_cnt;
  int               pending_results;
  idle_mode_e       idle_mode;
  logic             hold_off;
  int               routes_in_use;
  logic [ADDR_W-1:0] known_prefix [TABLE_DEPTH];
  logic [ADDR_W-1:0] known_mask   [TABLE_DEPTH];
  logic [ADDR_W-1:0] hot_net      [4];

  ipv4_lpm_in_if  in_if ();
  ipv4_lpm_out_if out_if ();

  ipv4_longest_prefix_lookup u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  ipv4_lpm_route_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  function automatic int idle_pct(bit for_sender);
    case (idle_mode)
      IDLE_SEND: idle_pct = for_sender ? 49 : 0;
      IDLE_RECV: idle_pct = for_sender ? 0 : 49;
      IDLE_BOTH: idle_pct = 29;
      default:   idle_pct = 0;
    endcase
  endfunction

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !hold_off && ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  function automatic lpm_in_t route_word(int idx, logic [ADDR_W-1:0] pfx,
                                         logic [ADDR_W-1:0] msk, logic [ADDR_W-1:0] nh,
                                         logic [PORT_W-1:0] port);
    lpm_in_t w;
    w.action      = ACT_WRITE;
    w.entry_index = ENTRY_W'(idx);
    w.prefix      = pfx;
    w.mask        = msk;
    w.next_hop_in = nh;
    w.port_in     = port;
    w.dest_addr   = $urandom;
    known_prefix[IDX_W'(idx)] = pfx;
    known_mask[IDX_W'(idx)]   = msk;
    return w;
  endfunction

  function automatic lpm_in_t lookup_word(logic [ADDR_W-1:0] dest);
    lpm_in_t w;
    w.action      = ACT_LOOKUP;
    w.entry_index = ENTRY_W'($urandom);
    w.prefix      = $urandom;
    w.mask        = $urandom;
    w.next_hop_in = $urandom;
    w.port_in     = PORT_W'($urandom);
    w.dest_addr   = dest;
    return w;
  endfunction

  // mostly prefix masks over a few busy networks so routes overlap
  function automatic lpm_in_t random_route(int idx);
    logic [ADDR_W-1:0] msk;
    logic [ADDR_W-1:0] pfx;
    int                plen;
    plen = $urandom_range(0, ADDR_W);
    msk = (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
    if ($urandom_range(0, 7) == 0) msk = $urandom;
    pfx = {hot_net[2'($urandom_range(0, 3))][31:16], 16'($urandom)} & msk;
    if ($urandom_range(0, 15) == 0) pfx = $urandom;
    return route_word(idx, pfx, msk, $urandom, PORT_W'($urandom));
  endfunction

  function automatic lpm_in_t random_lookup();
    logic [ADDR_W-1:0] dest;
    int                r;
    logic [IDX_W-1:0]  i;
    r = $urandom_range(0, 99);
    if (r < 65 && routes_in_use > 0) begin
      i = IDX_W'($urandom_range(0,
            ((routes_in_use > TABLE_DEPTH) ? TABLE_DEPTH : routes_in_use) - 1));
      dest = (known_prefix[i] & known_mask[i]) | ($urandom & ~known_mask[i]);
    end else if (r < 85) begin
      dest = {hot_net[2'($urandom_range(0, 3))][31:16], 16'($urandom)};
    end else if (r < 92) begin
      dest = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      dest = $urandom;
    end
    return lookup_word(dest);
  endfunction

  task automatic send_word(lpm_in_t w);
    while ($urandom_range(0, 99) < idle_pct(1'b1)) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic run_traffic(int n_words, int write_pct);
    repeat (n_words) begin
      if ($urandom_range(0, 99) < write_pct) begin
        send_word(random_route($urandom_range(0, TABLE_DEPTH - 1)));
      end else begin
        send_word(random_lookup());
      end
    end
  endtask

  // writes give no result, so wait out the chain after the last lookup
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_routes_in_use(int v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    routes_in_use = v;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    hold_off      = 1'b0;
    idle_mode     = IDLE_NONE;
    routes_in_use = 0;
    foreach (hot_net[k]) hot_net[k] = $urandom;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table: every lookup misses
    set_routes_in_use(0);
    send_word(lookup_word(32'h0000_0000));
    send_word(lookup_word(32'hffff_ffff));

    send_word(route_word(0, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_00fe, 4'd1));
    send_word(route_word(1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'd15));
    send_word(route_word(2, 32'h0a01_0000, 32'hffff_0000, 32'h0a01_00fe, 4'd2));
    send_word(route_word(3, 32'h0a01_0000, 32'hffff_0000, 32'h0a01_01fe, 4'd3));
    send_word(route_word(4, 32'h1200_3400, 32'hff00_ff00, 32'h1200_34fe, 4'd4));
    // prefix bits outside the mask: can never match
    send_word(route_word(5, 32'h0a01_00ff, 32'hffff_ff00, 32'h0a01_0001, 4'd5));
    send_word(route_word(6, 32'hc0a8_0100, 32'hffff_ff00, 32'h0000_0000, 4'd0));
    send_word(route_word(7, 32'h0000_0000, 32'h0000_0000, 32'h0101_0101, 4'd7));

    // default route left out, so misses are still possible
    set_routes_in_use(7);
    send_word(lookup_word(32'h0b00_0000));
    send_word(lookup_word(32'h0a01_0203));
    send_word(lookup_word(32'hffff_ffff));
    send_word(lookup_word(32'h12ab_34cd));
    send_word(lookup_word(32'h0a01_00ff));
    send_word(lookup_word(32'hc0a8_01ff));
    send_word(lookup_word(32'h0000_0000));

    set_routes_in_use(8);
    for (int i = 8; i < TABLE_DEPTH; i++) begin
      send_word(random_route(i));
      if ($urandom_range(0, 4) == 0) send_word(random_lookup());
    end

    set_routes_in_use(TABLE_DEPTH);
    idle_mode = IDLE_NONE;
    run_traffic(70, 15);

    set_routes_in_use((1 << CNT_W) - 1);
    idle_mode = IDLE_SEND;
    run_traffic(70, 15);

    set_routes_in_use(int'($urandom_range(9, TABLE_DEPTH - 1)));
    idle_mode = IDLE_RECV;
    run_traffic(70, 15);

    set_routes_in_use(1);
    idle_mode = IDLE_BOTH;
    run_traffic(70, 15);

    // long receiver hold-off while words keep coming, so the chain backs up
    set_routes_in_use(TABLE_DEPTH);
    idle_mode = IDLE_NONE;
    fork
      run_traffic(280, 10);
      begin
        repeat (16) @(posedge clk_i);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
